// File: rtl/indexed_list_store_macros.svh
// assertion macros for the indexed list store
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH
`ifndef SYNTH
`define ILS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ILS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ILS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ILS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/ils_pkg.sv
// shared types and constants of the indexed list store
package ils_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic [VAL_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET      = 3'd0,
    OP_ADD_HEAD = 3'd1,
    OP_ADD_TAIL = 3'd2,
    OP_ADD_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // what the decoded command turns into
  typedef enum logic [1:0] {
    DEC_GET,
    DEC_INSERT,
    DEC_DELETE,
    DEC_REJECT
  } dec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic rd_get;
    logic shift_step;
    logic place;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    dec_t kind;
    logic shift_none;
    logic shift_last;
    logic is_del;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/ils_cmd_if.sv
// command channel: opcode, position and value beat
interface ils_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [ils_pkg::OPCODE_W-1:0]      opcode;
  logic [ils_pkg::POS_W-1:0]         position;
  logic signed [ils_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, opcode, position, value_in, input ready);
  modport sink (input valid, opcode, position, value_in, output ready);
endinterface

// File: rtl/ils_rsp_if.sv
// result channel: value, status and length beat
interface ils_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ils_pkg::VAL_W-1:0]  value_out;
  logic [ils_pkg::STATUS_W-1:0]      status;
  logic [ils_pkg::LEN_W-1:0]         length;

  modport source (output valid, value_out, status, length, input ready);
  modport sink (input valid, value_out, status, length, output ready);
endinterface

// File: rtl/ils_ctrl.sv
// controller state machine of the indexed list store
`include "indexed_list_store_macros.svh"

module ils_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ils_pkg::dp_stat_t  stat,
  output ils_pkg::ctrl_cmd_t cmd
);

  ils_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ils_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ils_pkg::S_IDLE: begin
        if (in_valid) state_next = ils_pkg::S_EVAL;
      end
      ils_pkg::S_EVAL: begin
        unique case (stat.kind)
          ils_pkg::DEC_INSERT: begin
            state_next = stat.shift_none ? ils_pkg::S_PLACE : ils_pkg::S_SHIFT;
          end
          ils_pkg::DEC_DELETE: begin
            state_next = stat.shift_none ? ils_pkg::S_REPLY : ils_pkg::S_SHIFT;
          end
          default: state_next = ils_pkg::S_REPLY;
        endcase
      end
      ils_pkg::S_SHIFT: begin
        if (stat.shift_last) begin
          state_next = stat.is_del ? ils_pkg::S_REPLY : ils_pkg::S_DRAIN;
        end
      end
      ils_pkg::S_DRAIN: state_next = ils_pkg::S_PLACE;
      ils_pkg::S_PLACE: state_next = ils_pkg::S_REPLY;
      ils_pkg::S_REPLY: begin
        if (stat.out_free) state_next = ils_pkg::S_IDLE;
      end
      default: state_next = ils_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ils_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ils_pkg::S_EVAL: begin
        cmd.eval    = 1'b1;
        cmd.rd_get  = (stat.kind == ils_pkg::DEC_GET);
        cmd.cnt_dec = (stat.kind == ils_pkg::DEC_DELETE) && stat.shift_none;
      end
      ils_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.cnt_dec    = stat.shift_last && stat.is_del;
      end
      ils_pkg::S_DRAIN: begin
      end
      ils_pkg::S_PLACE: begin
        cmd.place   = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ils_pkg::S_REPLY: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  // shifting is only ever entered from evaluation or continued
  `ILS_ASSERT_IMP(a_shift_entry, clk, rst, state == ils_pkg::S_SHIFT, $past(state) == ils_pkg::S_EVAL || $past(state) == ils_pkg::S_SHIFT, "shift entered from wrong state")
  // placing a value always follows a drained shift or a no-shift insert
  `ILS_ASSERT_IMP(a_place_entry, clk, rst, state == ils_pkg::S_PLACE, $past(state) == ils_pkg::S_EVAL || $past(state) == ils_pkg::S_DRAIN, "place entered from wrong state")

endmodule

// File: rtl/ils_datapath.sv
// datapath: command registers, entry memory, shift pointers, count and result stage
`include "indexed_list_store_macros.svh"

module ils_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ils_pkg::OPCODE_W-1:0]      opcode,
  input  logic [ils_pkg::POS_W-1:0]         position,
  input  logic signed [ils_pkg::VAL_W-1:0]  value_in,
  input  ils_pkg::ctrl_cmd_t                cmd,
  output ils_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ils_pkg::VAL_W-1:0]  value_out,
  output logic [ils_pkg::STATUS_W-1:0]      status,
  output logic [ils_pkg::LEN_W-1:0]         length
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  logic [ils_pkg::OPCODE_W-1:0] op_r;
  logic [ils_pkg::POS_W-1:0]    pos_r;
  logic [ils_pkg::VAL_W-1:0]    val_r;
  logic [CW-1:0]                count;

  logic                         is_del;
  logic                         get_ok;
  ils_pkg::status_t             code_r;
  logic [AW-1:0]                tpos_a;
  logic [AW-1:0]                ptr;
  logic [AW-1:0]                wr_addr;
  logic                         wr_pend;

  logic [ils_pkg::VAL_W-1:0]    mem [CAPACITY];
  logic [ils_pkg::VAL_W-1:0]    rd_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;

  logic [CMPW-1:0]              pos_x;
  logic [CMPW-1:0]              cnt_x;
  logic [CMPW-1:0]              tpos_x;
  logic [CMPW-1:0]              pos_p1;
  logic [CMPW-1:0]              cnt_m1;
  logic                         full;
  ils_pkg::dec_t                kind;
  ils_pkg::status_t             code;

  assign pos_x  = CMPW'(pos_r);
  assign cnt_x  = CMPW'(count);
  assign pos_p1 = pos_x + CMPW'(1);
  assign cnt_m1 = cnt_x - CMPW'(1);
  assign full   = (count >= CW'(CAPACITY));

  always_comb begin
    unique case (op_r)
      ils_pkg::OP_ADD_HEAD: tpos_x = '0;
      ils_pkg::OP_ADD_TAIL: tpos_x = cnt_x;
      default:              tpos_x = pos_x;
    endcase
  end

  // command decode against the current length
  always_comb begin
    kind = ils_pkg::DEC_REJECT;
    code = ils_pkg::ST_INVALID;
    unique case (op_r)
      ils_pkg::OP_GET: begin
        if (pos_x < cnt_x) begin
          kind = ils_pkg::DEC_GET;
          code = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_ADD_HEAD, ils_pkg::OP_ADD_TAIL, ils_pkg::OP_ADD_AT: begin
        if (tpos_x > cnt_x) begin
          code = ils_pkg::ST_INVALID;
        end else if (full) begin
          code = ils_pkg::ST_FULL;
        end else begin
          kind = ils_pkg::DEC_INSERT;
          code = ils_pkg::ST_DONE;
        end
      end
      ils_pkg::OP_DELETE: begin
        if (pos_x < cnt_x) begin
          kind = ils_pkg::DEC_DELETE;
          code = ils_pkg::ST_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.kind       = kind;
  assign stat.shift_none = (kind == ils_pkg::DEC_DELETE) ? (pos_p1 == cnt_x)
                                                         : (tpos_x == cnt_x);
  assign stat.shift_last = is_del ? (ptr == cnt_m1[AW-1:0]) : (ptr == tpos_a);
  assign stat.is_del     = is_del;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      pos_r <= position;
      val_r <= value_in;
    end
    if (cmd.eval) begin
      is_del <= (kind == ils_pkg::DEC_DELETE);
      get_ok <= (kind == ils_pkg::DEC_GET);
      code_r <= code;
      tpos_a <= tpos_x[AW-1:0];
      ptr    <= (kind == ils_pkg::DEC_DELETE) ? pos_p1[AW-1:0] : cnt_m1[AW-1:0];
    end else if (cmd.shift_step) begin
      ptr <= is_del ? (ptr + AW'(1)) : (ptr - AW'(1));
    end
    if (cmd.shift_step) begin
      wr_addr <= is_del ? (ptr - AW'(1)) : (ptr + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      count   <= '0;
    end else begin
      wr_pend <= cmd.shift_step;
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  // entry memory: one write and one registered read per cycle
  assign rd_en   = cmd.rd_get || cmd.shift_step;
  assign rd_addr = cmd.shift_step ? ptr : pos_x[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= rd_data;
    end else if (cmd.place) begin
      mem[tpos_a] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value_out <= get_ok ? rd_data : ils_pkg::NO_VALUE;
      status    <= code_r;
      length    <= cnt_x[ils_pkg::LEN_W-1:0];
    end
  end

  `ILS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `ILS_ASSERT_IMP(a_one_write, clk, rst, wr_pend, !cmd.place, "shift write and place collide")
  `ILS_ASSERT_IMP(a_no_load_busy, clk, rst, cmd.out_load, !out_valid || out_ready, "result overwritten before taken")

endmodule

// File: rtl/indexed_list_store.sv
// top level of the indexed list store
`include "indexed_list_store_macros.svh"

// Ordered list of up to CAPACITY signed 32-bit entries, entry 0 at the head.
// Each command beat on cmd (get, add at head, add at tail, add at index,
// delete at index) yields exactly one result beat on rsp carrying the value
// read (-1 unless a valid get), a status (done, index invalid, store full)
// and the list length after the command, masked to 7 bits. Commands are
// processed one at a time: cmd.ready is high only while no command is in
// work, but a new command is taken while the previous result still waits in
// the output register. Inserts and deletes move the later entries one place
// per cycle through the entry memory (one write and one registered read per
// cycle). The memory needs no clearing after reset: only entries below the
// length are ever read.
module indexed_list_store #(
  parameter int CAPACITY = 64
) (
  input logic      clk,
  input logic      rst,
  ils_cmd_if.sink  cmd,
  ils_rsp_if.source rsp
);

  ils_pkg::ctrl_cmd_t ctl;
  ils_pkg::dp_stat_t  stat;

  // sequencing of decode, shift, place and reply
  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (stat),
    .cmd      (ctl)
  );

  // entry memory, count and result register
  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .opcode    (cmd.opcode),
    .position  (cmd.position),
    .value_in  (cmd.value_in),
    .cmd       (ctl),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .value_out (rsp.value_out),
    .status    (rsp.status),
    .length    (rsp.length)
  );

  // one command in work at a time
  `ILS_ASSERT_NXT(a_one_in_work, clk, rst, cmd.valid && cmd.ready, !cmd.ready, "second command taken while busy")

endmodule

// File: bench/list_result_checker.sv
// watches both channels of the list store, predicts each reply and compares it
module list_result_checker
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  ils_cmd_if          cmd,
  ils_rsp_if          rsp,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned list_length
);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
    logic [LEN_W-1:0]        length;
  } list_reply_t;

  // mirror of the list contents, head at entry 0
  logic signed [VAL_W-1:0] list_entries [CAPACITY];
  int unsigned             entry_total = 0;
  list_reply_t             expected_replies [$];

  int unsigned mismatch_total = 0;
  int unsigned pending_q      = 0;
  int unsigned length_q       = 0;

  assign mismatches  = mismatch_total;
  assign outstanding = pending_q;
  assign list_length = length_q;

  task automatic report_mismatch(input string what);
    $display("%0t ns list reply mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  function automatic status_t insert_entry(input int unsigned at,
                                           input logic signed [VAL_W-1:0] val);
    int unsigned i;
    // a bad index wins over a full store
    if (at > entry_total) return ST_INVALID;
    if (entry_total >= CAPACITY) return ST_FULL;
    for (i = entry_total; i > at; i--) list_entries[i] = list_entries[i-1];
    list_entries[at] = val;
    entry_total++;
    return ST_DONE;
  endfunction

  function automatic status_t delete_entry(input int unsigned at);
    int unsigned i;
    if (at >= entry_total) return ST_INVALID;
    for (i = at; i + 1 < entry_total; i++) list_entries[i] = list_entries[i+1];
    entry_total--;
    return ST_DONE;
  endfunction

  function automatic list_reply_t apply_list_command(input logic [OPCODE_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VAL_W-1:0] val);
    list_reply_t r;
    r.value  = NO_VALUE;
    r.status = ST_INVALID;
    case (op)
      OP_GET: begin
        if (pos < entry_total) begin
          r.value  = list_entries[pos];
          r.status = ST_DONE;
        end
      end
      OP_ADD_HEAD: r.status = insert_entry(0, val);
      OP_ADD_TAIL: r.status = insert_entry(entry_total, val);
      OP_ADD_AT:   r.status = insert_entry(pos, val);
      OP_DELETE:   r.status = delete_entry(pos);
      default:     r.status = ST_INVALID;
    endcase
    r.length = entry_total[LEN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      entry_total = 0;
      expected_replies.delete();
    end else begin
      // replies first: a reply never belongs to a command taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply with nothing pending (value %0d status %0d len %0d)",
                                    rsp.value_out, rsp.status, rsp.length));
        end else begin
          want = expected_replies.pop_front();
          if (rsp.value_out !== want.value)
            report_mismatch($sformatf("value_out %0d, expected %0d", rsp.value_out, want.value));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", rsp.length, want.length));
        end
      end
      if (cmd.valid && cmd.ready)
        expected_replies.push_back(apply_list_command(cmd.opcode, cmd.position, cmd.value_in));
    end
    pending_q <= expected_replies.size();
    length_q  <= entry_total;
  end

endmodule

// File: bench/indexed_list_store_test.sv
// stimulus and verdict for the indexed list store, checking done by list_result_checker
module indexed_list_store_test;
  import ils_pkg::*;

  localparam int CAPACITY     = 64;
  // outlasts the longest insert, so this covers any tail
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  // long receiver hold-off for the back-pressure phase
  localparam int HOLD_CYCLES  = 400;
  // a sender gap never runs longer than this
  localparam int MAX_GAP      = 200;

  // opcodes the block must reject
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [POS_W-1:0]        POS_TOP = '1;

  logic clk;
  logic rst;

  ils_cmd_if cmd_ch();
  ils_rsp_if rsp_ch();

  int unsigned fail_total;
  int unsigned replies_pending;
  int unsigned list_len_seen;

  // idle knobs: sender percent is used only by the stimulus process,
  // receiver percent and the hold request are handed over with nonblocking writes
  int   send_idle_pct = 0;
  int   stall_pct;
  logic hold_req;
  int   hold_left = 0;

  indexed_list_store #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  list_result_checker #(.CAPACITY(CAPACITY)) checker_inst (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .mismatches  (fail_total),
    .outstanding (replies_pending),
    .list_length (list_len_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("** indexed_list_store: FAILED **");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one command beat and hold it until taken; valid stays high into the
  // next beat unless a gap is drawn, so it is never dropped and raised in one step
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val);
    int gap;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.position <= pos;
    cmd_ch.value_in <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random commands in alternating stretches: one stretch leans to inserts so
  // the store fills and hits the full case, the next leans to deletes so it
  // empties again; positions mostly land inside or right at the end of the list
  task automatic send_random_cmds(input int count);
    int unsigned pick;
    int unsigned reach;
    bit growing;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [VAL_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      growing = ((n / 128) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 15)                        op = OP_GET;
      else if (pick < (growing ? 33 : 21))  op = OP_ADD_HEAD;
      else if (pick < (growing ? 51 : 27))  op = OP_ADD_TAIL;
      else if (pick < (growing ? 80 : 40))  op = OP_ADD_AT;
      else if (pick < 97)                   op = OP_DELETE;
      else op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

      reach = $urandom_range(0, 9);
      if (reach == 0)
        pos = POS_W'($urandom_range(0, POS_TOP));  // anything, mostly out of range
      else if (reach == 1)
        pos = POS_W'(list_len_seen);               // just past the last entry
      else
        pos = POS_W'($urandom_range(0, (list_len_seen > 0) ? list_len_seen - 1 : 0));

      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = VAL_MAX;
          1:       val = VAL_MIN;
          2:       val = '0;
          default: val = '1;
        endcase
      end else begin
        val = $urandom;
      end
      send_cmd(op, pos, val);
    end
  endtask

  initial begin
    // every input known from time zero
    rst             = 1'b1;
    stall_pct       = 0;
    hold_req        = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.opcode   = OP_GET;
    cmd_ch.position = '0;
    cmd_ch.value_in = '0;
    rsp_ch.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, both ends, extremes, bad indexes and undefined opcodes
    send_cmd(OP_GET,      '0,      32'sd9);     // get on empty list
    send_cmd(OP_DELETE,   '0,      32'sd9);     // delete on empty list
    send_cmd(OP_ADD_AT,   7'd1,    32'sd3);     // insert past the end
    send_cmd(OP_ADD_AT,   '0,      32'sd5);     // index equal to length appends
    send_cmd(OP_ADD_HEAD, '0,      VAL_MAX);
    send_cmd(OP_ADD_TAIL, '0,      VAL_MIN);
    send_cmd(OP_ADD_AT,   7'd1,    -32'sd1);    // insert in the middle
    send_cmd(OP_ADD_AT,   7'd4,    '0);         // append through add at index
    send_cmd(OP_ADD_AT,   POS_TOP, 32'sd1);     // far past the end
    send_cmd(OP_GET,      '0,      '0);
    send_cmd(OP_GET,      7'd4,    '0);         // last entry
    send_cmd(OP_GET,      7'd5,    '0);         // one past the end
    send_cmd(OP_GET,      POS_TOP, '1);
    send_cmd(OP_DELETE,   POS_TOP, '0);
    send_cmd(OP_DELETE,   7'd4,    '0);         // drop the tail
    send_cmd(OP_DELETE,   '0,      '0);         // drop the head
    send_cmd(OP_GET,      '0,      '0);
    send_cmd(OP_UNUSED_LO, POS_TOP, VAL_MAX);   // undefined opcodes are rejected
    send_cmd(OP_UNUSED_HI, '0,     VAL_MIN);
    send_cmd(OP_ADD_TAIL, POS_TOP, 32'sh5555_5555);  // position ignored
    send_cmd(OP_ADD_HEAD, POS_TOP, 32'shAAAA_AAAA);

    // random phases with different idle patterns
    send_random_cmds(480);                      // back to back on both sides

    send_idle_pct = 87;
    send_random_cmds(480);                      // sparse commands

    send_idle_pct = 0;
    stall_pct <= 87;
    send_random_cmds(480);                      // result side mostly stalled

    send_idle_pct = 24;
    stall_pct <= 24;
    send_random_cmds(420);                      // light idling on both sides

    // back-pressure: results held off for a long stretch while commands keep
    // coming, so the output register fills and the command side stalls
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_req  <= 1'b1;
    send_random_cmds(60);

    // release the command side so the last beat is not taken again
    cmd_ch.valid <= 1'b0;

    // the pending count is registered, so wait for a clock edge before polling it
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_total == 0)
      $display("** indexed_list_store: PASSED **");
    else
      $display("** indexed_list_store: FAILED **");
    $finish;
  end

endmodule
